// ===== sv/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Used by the front classifier, the command queue, the back executor and the top level.
package tcw_pkg;

  // Input kind codes.
  localparam logic [2:0] KIND_PUT_CHAR = 3'd0;
  localparam logic [2:0] KIND_SET_ROW  = 3'd1;
  localparam logic [2:0] KIND_SET_COL  = 3'd2;
  localparam logic [2:0] KIND_CLEAR    = 3'd3;
  localparam logic [2:0] KIND_READ     = 3'd4;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Cell value after reset: a space, grey on black.
  localparam logic [15:0] RESET_CELL = 16'h0720;

  // Register map: bit 2 of the byte address selects the register word.
  localparam logic       REG_TEXT_COLOR   = 1'b0;
  localparam logic [7:0] TEXT_COLOR_RESET = 8'd7;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;

  // Classified command handed from the front to the back.
  typedef enum logic [2:0] {
    OP_PRINT     = 3'd0,
    OP_NEWLINE   = 3'd1,
    OP_BACKSPACE = 3'd2,
    OP_SET_ROW   = 3'd3,
    OP_SET_COL   = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_READ      = 3'd6,
    OP_NOP       = 3'd7
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  ch;
    logic [4:0]  row;   // already clamped to the last row
    logic [6:0]  col;   // already clamped to the last column
    logic [10:0] idx;   // in range whenever op is OP_READ
  } cmd_t;

endpackage

// ===== sv/tcw_front.sv =====
// Front part of the text console writer: accepts input beats and classifies them.
// Depends on tcw_pkg for the kind codes, character codes and the command type.
module tcw_front
  import tcw_pkg::*;
#(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [7:0]  char_code,
  input  logic [4:0]  new_row,
  input  logic [6:0]  new_column,
  input  logic [10:0] cell_index,
  input  logic        q_full,
  input  logic        init_busy,
  output logic        push,
  output cmd_t        cmd
);

  localparam int          CELLS    = ROWS * COLUMNS;
  localparam logic [4:0]  LAST_ROW = 5'(ROWS - 1);
  localparam logic [6:0]  LAST_COL = 7'(COLUMNS - 1);

  // Hold the input off while the queue is full or the grid is being initialised.
  assign in_stall = q_full | init_busy;
  assign push     = in_valid & ~in_stall;

  // Decode the kind into a command and clamp the cursor targets.
  always_comb begin
    cmd.ch  = char_code;
    cmd.row = (new_row > LAST_ROW) ? LAST_ROW : new_row;
    cmd.col = (new_column > LAST_COL) ? LAST_COL : new_column;
    cmd.idx = cell_index;
    unique case (kind)
      KIND_PUT_CHAR: begin
        if (char_code == CH_NEWLINE) begin
          cmd.op = OP_NEWLINE;
        end else if (char_code == CH_BACKSPACE) begin
          cmd.op = OP_BACKSPACE;
        end else begin
          cmd.op = OP_PRINT;
        end
      end
      KIND_SET_ROW: cmd.op = OP_SET_ROW;
      KIND_SET_COL: cmd.op = OP_SET_COL;
      KIND_CLEAR:   cmd.op = OP_CLEAR;
      KIND_READ: begin
        // An index beyond the grid reads as zero, which is what a no-op returns.
        cmd.op = (32'(cell_index) < CELLS) ? OP_READ : OP_NOP;
      end
      default: cmd.op = OP_NOP;
    endcase
  end

endmodule

// ===== sv/tcw_queue.sv =====
// Short command queue between the front and the back of the text console writer.
// Depends on tcw_pkg for the command type and the queue depth.
module tcw_queue
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int NW = $clog2(Q_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(Q_DEPTH - 1);

  cmd_t          slots [Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign empty   = (count == '0);
  assign full    = (count == NW'(Q_DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (!do_push && do_pop) begin
        count <= count - NW'(1);
      end
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(Q_DEPTH))
    else $error("queue fill count beyond its depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (rd_ptr == wr_ptr))
    else $error("empty queue with pointers apart");
`endif

endmodule

// ===== sv/tcw_back.sv =====
// Back part of the text console writer: owns the cell memory and the cursor, runs commands.
// Depends on tcw_pkg for the command type and constants; fed by tcw_queue.
module tcw_back
  import tcw_pkg::*;
#(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  text_color,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        init_busy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_column,
  output logic [10:0] cursor_offset,
  output logic [15:0] cell_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_COPY  = 6'b001000,
    S_BLANK = 6'b010000,
    S_CLEAR = 6'b100000
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [AW-1:0] cnt;
  logic [AW-1:0] cnt_next;
  logic [RW-1:0] row;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col;
  logic [CW-1:0] col_next;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;

  logic [15:0]   blank;
  logic [AW-1:0] cur_addr;
  logic [10:0]   offset_next;
  logic          out_free;
  logic          emit;
  logic [15:0]   emit_data;

  assign blank       = {text_color, CH_SPACE};
  assign cur_addr    = AW'(32'(row) * COLUMNS + 32'(col));
  assign offset_next = 11'(32'(row_next) * COLUMNS + 32'(col_next));
  assign out_free    = ~out_valid | ~out_stall;
  assign init_busy   = (state == S_INIT);

  // Command sequencer: simple commands finish at the pop, a read waits in S_READ, sweeps run over the grid.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    row_next   = row;
    col_next   = col;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_data  = '0;
    we         = 1'b0;
    waddr      = cur_addr;
    wdata      = blank;
    re         = 1'b0;
    raddr      = AW'(q_head.idx);
    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        waddr = cnt;
        wdata = RESET_CELL;
        if (cnt == LAST_CELL) begin
          state_next = S_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      S_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          case (q_head.op)
            OP_PRINT, OP_NEWLINE: begin
              if (q_head.op == OP_PRINT) begin
                we    = 1'b1;
                wdata = {text_color, q_head.ch};
              end
              if (q_head.op == OP_PRINT && col != LAST_COL) begin
                col_next = col + CW'(1);
                emit     = 1'b1;
              end else begin
                col_next = '0;
                if (row == LAST_ROW) begin
                  // Past the last row: scroll the grid up one row.
                  state_next = S_COPY;
                  cnt_next   = '0;
                end else begin
                  row_next = row + RW'(1);
                  emit     = 1'b1;
                end
              end
            end
            OP_BACKSPACE: begin
              if (col != '0) begin
                col_next = col - CW'(1);
              end else if (row != '0) begin
                row_next = row - RW'(1);
                col_next = LAST_COL;
              end
              // Moving left with wrap is one step back in the linear address.
              we    = 1'b1;
              waddr = (cur_addr == '0) ? '0 : cur_addr - AW'(1);
              emit  = 1'b1;
            end
            OP_SET_ROW: begin
              row_next = RW'(q_head.row);
              emit     = 1'b1;
            end
            OP_SET_COL: begin
              col_next = CW'(q_head.col);
              emit     = 1'b1;
            end
            OP_CLEAR: begin
              state_next = S_CLEAR;
              cnt_next   = '0;
            end
            OP_READ: begin
              re         = 1'b1;
              state_next = S_READ;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        emit       = 1'b1;
        emit_data  = rdata;
        state_next = S_IDLE;
      end
      S_COPY: begin
        // Read one row ahead and write the previous read in the next cycle.
        re    = (cnt != COPY_END);
        raddr = cnt + ROW_STEP;
        we    = (cnt != '0);
        waddr = cnt - AW'(1);
        wdata = rdata;
        if (cnt == COPY_END) begin
          state_next = S_BLANK;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      S_BLANK, S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt;
        if (cnt == LAST_CELL) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      row       <= '0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      row       <= row_next;
      col       <= col_next;
      out_valid <= emit | (out_valid & out_stall);
    end
  end

  // Result register: loaded only when the previous beat has gone.
  always_ff @(posedge clk) begin
    if (emit) begin
      cursor_row    <= 5'(row_next);
      cursor_column <= 7'(col_next);
      cursor_offset <= offset_next;
      cell_data     <= emit_data;
    end
  end

  // Cell memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result produced while the output register is still held");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (row <= LAST_ROW) && (col <= LAST_COL))
    else $error("cursor outside the grid");

  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_COPY || state == S_BLANK || state == S_CLEAR)
      |-> !out_valid)
    else $error("output beat pending during a multi-cycle command");
`endif

endmodule

// ===== sv/text_console_writer_top.sv =====
// Top level of the text console writer: register port, front, queue and back.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_stall   kind, char_code, new_row, new_column, cell_index
//   output   out        out_valid / out_stall cursor_row, cursor_column, cursor_offset, cell_data
//   config   in         psel / penable / APB  paddr, pwdata, prdata (text_color at 0)
//
// Cursor moves, character writes and backspace pass from the queue to the back, which registers the result.
// A cell read passes through the queue, the registered read port of the cell memory and the result register.
// A clear walks the grid at one cell a cycle; a scroll first copies the rows up, then blanks the last row.
// After reset a pass over the grid writes every cell; no input beat is taken then.
// A stalled output holds the back; the two-entry queue keeps taking input until it is full.
module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [7:0]  char_code,
  input  logic [4:0]  new_row,
  input  logic [6:0]  new_column,
  input  logic [10:0] cell_index,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_column,
  output logic [10:0] cursor_offset,
  output logic [15:0] cell_data
);

  logic [7:0] text_color;
  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  logic       init_busy;
  cmd_t       push_cmd;
  cmd_t       q_head;

  // Register port: no wait states.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= TEXT_COLOR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_COLOR)) begin
      text_color <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TEXT_COLOR) begin
      prdata = {24'd0, text_color};
    end
  end

  tcw_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .char_code  (char_code),
    .new_row    (new_row),
    .new_column (new_column),
    .cell_index (cell_index),
    .q_full     (q_full),
    .init_busy  (init_busy),
    .push       (q_push),
    .cmd        (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  tcw_back #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .text_color    (text_color),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .init_busy     (init_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column),
    .cursor_offset (cursor_offset),
    .cell_data     (cell_data)
  );

endmodule
